/* rtl/core/wpsc_pkg.sv */
// ----------------------------------------------------------------------------
// wpsc_pkg: shared definitions for the window pair sum checker
// Sizes, register reset values, controller states and the control bundle that
// the controller broadcasts to every window cell.
// ----------------------------------------------------------------------------
package wpsc_pkg;

  localparam int WINDOW_MAX = 32;
  localparam int IDX_W      = $clog2(WINDOW_MAX);
  localparam int LEN_W      = $clog2(WINDOW_MAX + 1);
  localparam int POS_W      = IDX_W + 1;
  localparam int CFG_W      = 6;
  localparam int DATA_W     = 64;

  localparam logic [CFG_W-1:0] LEN_MIN   = CFG_W'(2);
  localparam logic [CFG_W-1:0] LEN_MAX   = CFG_W'(WINDOW_MAX);
  localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(25);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Broadcast to all cells. During a scan the ring rotates one place per
  // cycle and every cell compares its word against match.
  typedef struct packed {
    logic              shift;
    logic              rotate;
    logic [DATA_W-1:0] shift_word;
    logic [DATA_W-1:0] match;
    logic [IDX_W-1:0]  step;
    logic [LEN_W-1:0]  len;
  } chain_ctrl_t;

endpackage

/* rtl/core/window_pair_sum_checker_top.sv */
// ----------------------------------------------------------------------------
// window_pair_sum_checker_top: sliding window two-sum check
// A word that is not checked goes from acceptance to ST_DONE, which registers
// the result; a checked word first takes 32 scan steps in ST_SCAN, one window
// entry per cycle, set by the rotation of the cell ring. A new word is taken
// in the cycle after the result is registered, never before the last word is
// through; ST_DONE holds while the receiver stalls a pending result.
// Reset (rst, synchronous): window empty, window_len back to 25, no result.
// ----------------------------------------------------------------------------
module window_pair_sum_checker_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [wpsc_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        value_valid,
  output logic                        value_stall,
  input  logic [wpsc_pkg::DATA_W-1:0] value,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic                        checked,
  output logic                        pair_found,
  output logic [wpsc_pkg::DATA_W-1:0] value_out
);
  import wpsc_pkg::*;

  state_t            state, state_next;
  logic [CFG_W-1:0]  window_len;
  logic [CFG_W-1:0]  len_eff;
  logic [LEN_W-1:0]  fill_count;
  logic [IDX_W-1:0]  step;
  logic [DATA_W-1:0] target;
  logic              is_checked;
  logic              found;
  logic              accept;
  logic              finish;
  logic [DATA_W-1:0] head;
  logic              any_hit;
  chain_ctrl_t       ctrl;

  always_comb begin
    len_eff = window_len;
    if (window_len < LEN_MIN) begin
      len_eff = LEN_MIN;
    end else if (window_len > LEN_MAX) begin
      len_eff = LEN_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= LEN_RESET;
    end else if (cfg_we) begin
      window_len <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    value_stall = 1'b1;
    accept      = 1'b0;
    finish      = 1'b0;
    case (state)
      ST_IDLE: begin
        value_stall = 1'b0;
        accept      = value_valid;
        if (value_valid) begin
          if (fill_count >= LEN_W'(len_eff)) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (step == IDX_W'(WINDOW_MAX - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!result_valid || !result_stall) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // The partner that cell zero's entry needs, compared in every cell at once.
  always_comb begin
    ctrl.shift      = finish;
    ctrl.rotate     = (state == ST_SCAN);
    ctrl.shift_word = target;
    ctrl.match      = target - head;
    ctrl.step       = step;
    ctrl.len        = LEN_W'(len_eff);
  end

  wpsc_chain u_chain (
    .clk     (clk),
    .ctrl    (ctrl),
    .head    (head),
    .any_hit (any_hit)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      target     <= value;
      is_checked <= (fill_count >= LEN_W'(len_eff));
      found      <= 1'b0;
      step       <= '0;
    end else if (state == ST_SCAN) begin
      found <= found | any_hit;
      step  <= step + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (finish && (fill_count < LEN_W'(WINDOW_MAX))) begin
      fill_count <= fill_count + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (finish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      checked    <= is_checked;
      pair_found <= found;
      value_out  <= target;
    end
  end

endmodule

/* rtl/core/wpsc_cell.sv */
// ----------------------------------------------------------------------------
// wpsc_cell: one window entry
// Holds one word of the window. It loads from its lower neighbor when a new
// word is shifted in and from its upper neighbor while the ring rotates, and
// flags a match against the broadcast partner value.
// ----------------------------------------------------------------------------
module wpsc_cell (
  input  logic                       clk,
  input  wpsc_pkg::chain_ctrl_t      ctrl,
  input  logic [wpsc_pkg::IDX_W-1:0] cell_idx,
  input  logic [wpsc_pkg::DATA_W-1:0] from_lower,
  input  logic [wpsc_pkg::DATA_W-1:0] from_upper,
  output logic [wpsc_pkg::DATA_W-1:0] word,
  output logic                       hit
);
  import wpsc_pkg::*;

  logic [POS_W-1:0] pos;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      word <= from_lower;
    end else if (ctrl.rotate) begin
      word <= from_upper;
    end
  end

  // At scan step s this cell holds the entry cell_idx + s steps back, which
  // pairs with the entry s steps back that sits in cell zero.
  always_comb begin
    pos = {1'b0, cell_idx} + {1'b0, ctrl.step};
    hit = ctrl.rotate && (cell_idx != '0) && (pos < POS_W'(ctrl.len)) &&
          (word == ctrl.match);
  end

endmodule

/* rtl/core/wpsc_chain.sv */
// ----------------------------------------------------------------------------
// wpsc_chain: ring of window cells
// Cell k holds the entry k steps back from the newest. New words enter at
// cell zero; a rotation moves every word one cell down and wraps the bottom
// word to the top, so a full pass restores the original order.
// ----------------------------------------------------------------------------
module wpsc_chain (
  input  logic                        clk,
  input  wpsc_pkg::chain_ctrl_t       ctrl,
  output logic [wpsc_pkg::DATA_W-1:0] head,
  output logic                        any_hit
);
  import wpsc_pkg::*;

  logic [DATA_W-1:0]     words [WINDOW_MAX];
  logic [WINDOW_MAX-1:0] hits;

  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
    logic [DATA_W-1:0] lower;
    if (k == 0) begin : g_first
      assign lower = ctrl.shift_word;
    end else begin : g_rest
      assign lower = words[k-1];
    end

    wpsc_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .cell_idx   (IDX_W'(k)),
      .from_lower (lower),
      .from_upper (words[(k + 1) % WINDOW_MAX]),
      .word       (words[k]),
      .hit        (hits[k])
    );
  end

  assign head    = words[0];
  assign any_hit = |hits;

endmodule

/* tb/window_pair_sum_checker_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_pair_sum_checker_top_tb: self-checking bench for the pair sum checker
// Streams 64-bit words through the block under a range of window lengths,
// including lengths that the block clamps. A shadow window in the bench
// computes checked, pair_found and the echoed word for every accepted word.
// A monitor compares each delivered result with the oldest outstanding one.
// Sender gaps and receiver stalls vary within and between phases.
// ----------------------------------------------------------------------------
module window_pair_sum_checker_top_tb;
  import wpsc_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 9;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_WORDS  = 138;
  localparam int NUM_PHASES   = 13;
  localparam int PHASE_W      = $clog2(NUM_PHASES);
  localparam int FIFO_DEPTH   = 16;
  localparam int FIFO_W       = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic              checked;
    logic              pair_found;
    logic [DATA_W-1:0] value_out;
  } pair_check_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC
  } stall_style_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              value_valid = 1'b0;
  logic              value_stall;
  logic [DATA_W-1:0] value = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic              checked;
  logic              pair_found;
  logic [DATA_W-1:0] value_out;

  // Shadow copy of the window and the length register.
  logic [DATA_W-1:0] shadow_ring [WINDOW_MAX];
  int unsigned       shadow_fill = 0;
  int unsigned       shadow_next = 0;
  logic [CFG_W-1:0]  shadow_len = LEN_RESET;

  // Outstanding results, oldest at want_rd.
  pair_check_t  want_fifo [FIFO_DEPTH];
  int unsigned  want_wr = 0;
  int unsigned  want_rd = 0;
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;

  int unsigned  burst_left = 0;
  int unsigned  gap_max = 0;
  stall_style_t stall_style = STALL_NONE;
  int unsigned  stall_pct = 0;
  int unsigned  stall_period = 1;
  int unsigned  stall_duty = 0;
  int unsigned  stall_phase = 0;

  window_pair_sum_checker_top uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .value_valid  (value_valid),
    .value_stall  (value_stall),
    .value        (value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .checked      (checked),
    .pair_found   (pair_found),
    .value_out    (value_out)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    case (stall_style)
      STALL_RANDOM: begin
        result_stall <= ($urandom_range(99, 0) < stall_pct);
      end
      STALL_PERIODIC: begin
        result_stall <= ((stall_phase % stall_period) < stall_duty);
      end
      default: begin
        result_stall <= 1'b0;
      end
    endcase
  end

  always @(posedge clk) begin : check_results
    pair_check_t want;
    if (!rst && result_valid && !result_stall) begin
      if (want_wr == want_rd) begin
        $error("result with no word outstanding: value_out %h", value_out);
        error_count++;
      end else begin
        want = want_fifo[want_rd[FIFO_W-1:0]];
        want_rd++;
        if (checked !== want.checked) begin
          $error("checked: expected %0b, actual %0b", want.checked, checked);
          error_count++;
        end
        if (pair_found !== want.pair_found) begin
          $error("pair_found: expected %0b, actual %0b", want.pair_found, pair_found);
          error_count++;
        end
        if (value_out !== want.value_out) begin
          $error("value_out: expected %h, actual %h", want.value_out, value_out);
          error_count++;
        end
      end
    end
  end

  function automatic int unsigned active_len();
    if (shadow_len < LEN_MIN) begin
      return 32'(LEN_MIN);
    end
    if (shadow_len > LEN_MAX) begin
      return 32'(LEN_MAX);
    end
    return 32'(shadow_len);
  endfunction

  // Entry k places back from the newest word in the shadow window.
  function automatic logic [DATA_W-1:0] recent_word(int unsigned k);
    return shadow_ring[IDX_W'((shadow_next + 2 * WINDOW_MAX - 1 - k) % WINDOW_MAX)];
  endfunction

  function automatic logic pair_sums_to(logic [DATA_W-1:0] target, int unsigned len);
    for (int unsigned a = 0; a < len; a++) begin
      for (int unsigned b = a + 1; b < len; b++) begin
        if (recent_word(a) + recent_word(b) == target) begin
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  task automatic record_pair_check(input logic [DATA_W-1:0] word);
    pair_check_t outcome;
    int unsigned len;
    len = active_len();
    outcome.checked    = (shadow_fill >= len);
    outcome.pair_found = outcome.checked && pair_sums_to(word, len);
    outcome.value_out  = word;
    want_fifo[want_wr[FIFO_W-1:0]] = outcome;
    want_wr++;
    shadow_ring[IDX_W'(shadow_next)] = word;
    shadow_next = (shadow_next + 1) % WINDOW_MAX;
    if (shadow_fill < WINDOW_MAX) begin
      shadow_fill++;
    end
  endtask

  // Valid stays high across a burst; a gap is only opened before a new one.
  task automatic send_word(input logic [DATA_W-1:0] word);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
      if (gap > 0) begin
        value_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    value_valid <= 1'b1;
    value <= word;
    do @(posedge clk); while (value_stall);
    record_pair_check(word);
  endtask

  task automatic drain_results();
    value_valid <= 1'b0;
    burst_left = 0;
    while (want_wr != want_rd) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_window_len(input logic [CFG_W-1:0] len);
    cfg_we <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_len = len;
    @(posedge clk);
  endtask

  task automatic choose_traffic();
    case ($urandom_range(3, 0))
      0: begin
        gap_max = 0;
        stall_style = STALL_NONE;
      end
      1: begin
        gap_max = 8;
        stall_style = STALL_RANDOM;
        stall_pct = $urandom_range(80, 10);
      end
      2: begin
        gap_max = 3;
        stall_style = STALL_PERIODIC;
        stall_period = $urandom_range(8, 2);
        stall_duty = $urandom_range(stall_period - 1, 1);
      end
      default: begin
        gap_max = $urandom_range(40, 1);
        stall_style = STALL_RANDOM;
        stall_pct = 30;
      end
    endcase
  endtask

  // About two in five picks are sums of two words inside the window; the rest are near misses and noise.
  function automatic logic [DATA_W-1:0] pick_word();
    int unsigned len;
    int unsigned held;
    int unsigned a;
    int unsigned b;
    int unsigned sel;
    len = active_len();
    held = (shadow_fill < len) ? shadow_fill : len;
    sel = $urandom_range(99, 0);
    if (held < 2 || sel < 15) begin
      return {$urandom, $urandom};
    end
    a = $urandom_range(held - 1, 0);
    b = $urandom_range(held - 2, 0);
    if (b >= a) begin
      b++;
    end
    if (sel < 55) begin
      return recent_word(a) + recent_word(b);
    end
    if (sel < 65 && shadow_fill > len) begin
      return recent_word(a) + recent_word(len);
    end
    if (sel < 72) begin
      return recent_word(a) << 1;
    end
    if (sel < 78) begin
      return recent_word(a) + recent_word(b) + 1;
    end
    if (sel < 90) begin
      return DATA_W'($urandom_range(15, 0));
    end
    return ~DATA_W'($urandom_range(15, 0));
  endfunction

  // With the length left at its reset value nothing can be checked yet.
  task automatic test_reset_length();
    send_word('0);
    send_word('1);
    send_word({1'b1, {(DATA_W - 1){1'b0}}});
  endtask

  task automatic test_smallest_window();
    drain_results();
    write_window_len(LEN_MIN);
    send_word(DATA_W'(10));
    send_word(DATA_W'(10));
    send_word(DATA_W'(20));
    send_word(DATA_W'(30));
    send_word('1);
    // The largest word plus 30 wraps around to 29.
    send_word(DATA_W'(29));
  endtask

  task automatic test_clamped_short();
    drain_results();
    write_window_len(CFG_W'(0));
    send_word(DATA_W'(28));
    drain_results();
    write_window_len(CFG_W'(1));
    send_word('0);
  endtask

  // A partner one place beyond the window must not count.
  task automatic test_window_boundary();
    drain_results();
    write_window_len(CFG_W'(3));
    send_word(recent_word(0) + recent_word(3));
    send_word(recent_word(1) + recent_word(2));
  endtask

  task automatic test_random_phases();
    logic [CFG_W-1:0] lens [NUM_PHASES];
    lens = '{LEN_MAX, '1, LEN_MIN, CFG_W'(33), CFG_W'(17), CFG_W'(0), CFG_W'(31),
             CFG_W'(1), LEN_RESET, CFG_W'(5), LEN_MAX, CFG_W'(42), CFG_W'(12)};
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      write_window_len(lens[PHASE_W'(p)]);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (i % 50 == 0) begin
          choose_traffic();
        end
        send_word(pick_word());
      end
    end
  endtask

  task automatic test_random_length();
    drain_results();
    write_window_len(CFG_W'($urandom_range(63, 0)));
    for (int i = 0; i < PHASE_WORDS; i++) begin
      if (i % 50 == 0) begin
        choose_traffic();
      end
      send_word(pick_word());
    end
  endtask

  initial begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      shadow_ring[IDX_W'(i)] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_length();
    test_smallest_window();
    test_clamped_short();
    test_window_boundary();
    test_random_phases();
    test_random_length();

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/wpsc_pkg.sv
rtl/core/wpsc_cell.sv
rtl/core/wpsc_chain.sv
rtl/core/window_pair_sum_checker_top.sv
tb/window_pair_sum_checker_top_tb.sv
